[rtl/assert_macros.svh]
// Assertion macros used by the checker in deq_checker.sv.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies; the interfaces, modules and testbench import this package.
package deq_pkg;

	localparam int DEQ_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;

	typedef enum logic [OP_W-1:0] {
		OP_NOP        = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4
	} deq_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} deq_state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic                     is_empty;
		logic                     is_full;
		logic                     op_error;
	} deq_result_t;

endpackage

[rtl/deq_if.sv]
// Valid/ready channel interfaces for queue operations and results.
// Depends on deq_pkg for field widths.
interface deq_req_if import deq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] popped_value;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic                     is_empty;
	logic                     is_full;
	logic                     op_error;

	modport source (output valid, output popped_value, output front_value,
		output back_value, output is_empty, output is_full, output op_error,
		input ready);
	modport sink (input valid, input popped_value, input front_value,
		input back_value, input is_empty, input is_full, input op_error,
		output ready);
endinterface

[rtl/double_ended_queue.sv]
// Bounded double-ended queue over a ring store with a registered result word.
// Push, no-op, rejected and draining pops: result valid in the cycle after acceptance, one word
// per cycle while results are consumed; other pops read the new end from the store in ST_READ.
// In ST_IDLE a new word is taken in the cycle the previous result is consumed.
// Reset clears state, indices, count and the valid flag; the store holds no reset value.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = DEQ_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	localparam int IW = $clog2(DEPTH);

	deq_result_t       rsp_data;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	deq_core #(.DEPTH(DEPTH)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_op         (req.op),
		.req_push_value (req.push_value),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_data       (rsp_data),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

	deq_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp.popped_value = rsp_data.popped_value;
	assign rsp.front_value  = rsp_data.front_value;
	assign rsp.back_value   = rsp_data.back_value;
	assign rsp.is_empty     = rsp_data.is_empty;
	assign rsp.is_full      = rsp_data.is_full;
	assign rsp.op_error     = rsp_data.op_error;

endmodule

[rtl/deq_ram.sv]
// Element store: one write port and one read port with registered read data.
// Depends on deq_pkg for the data width.
module deq_ram import deq_pkg::*; #(
	parameter int DEPTH = DEQ_DEPTH,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/deq_core.sv]
// Queue control: ring indices, count, cached end values and the result register.
// Depends on deq_pkg; drives the element store in deq_ram.
module deq_core import deq_pkg::*; #(
	parameter int DEPTH = DEQ_DEPTH,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [OP_W-1:0]          req_op,
	input  logic signed [DATA_W-1:0] req_push_value,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output deq_result_t              rsp_data,
	output logic                     ram_we,
	output logic [IW-1:0]            ram_waddr,
	output logic [DATA_W-1:0]        ram_wdata,
	output logic                     ram_re,
	output logic [IW-1:0]            ram_raddr,
	input  logic [DATA_W-1:0]        ram_rdata
);

	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	deq_state_t               state_q, state_n;
	logic [IW-1:0]            front_idx_q, front_idx_n;
	logic [IW-1:0]            back_idx_q, back_idx_n;
	logic [CW-1:0]            count_q, count_n;
	logic signed [DATA_W-1:0] front_val_q, front_val_n;
	logic signed [DATA_W-1:0] back_val_q, back_val_n;
	logic signed [DATA_W-1:0] popped_q, popped_n;
	logic                     pop_front_q, pop_front_n;
	logic                     out_valid_q;
	deq_result_t              out_data_q, result;
	logic                     err;
	logic                     done;
	logic                     accept;
	logic                     is_empty_now;
	logic                     is_full_now;
	logic [IW-1:0]            front_inc, front_dec, back_inc, back_dec;

	assign req_ready    = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign accept       = req_valid && req_ready;
	assign is_empty_now = (count_q == '0);
	assign is_full_now  = (count_q == FULL_CNT);

	assign front_inc = (front_idx_q == LAST_IDX) ? '0 : front_idx_q + 1'b1;
	assign front_dec = (front_idx_q == '0) ? LAST_IDX : front_idx_q - 1'b1;
	assign back_inc  = (back_idx_q == LAST_IDX) ? '0 : back_idx_q + 1'b1;
	assign back_dec  = (back_idx_q == '0) ? LAST_IDX : back_idx_q - 1'b1;

	always_comb begin
		state_n     = state_q;
		front_idx_n = front_idx_q;
		back_idx_n  = back_idx_q;
		count_n     = count_q;
		front_val_n = front_val_q;
		back_val_n  = back_val_q;
		popped_n    = popped_q;
		pop_front_n = pop_front_q;
		err         = 1'b0;
		done        = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = front_idx_q;
		ram_wdata   = req_push_value;
		ram_re      = 1'b0;
		ram_raddr   = front_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					done     = 1'b1;
					popped_n = '0;
					unique case (req_op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (is_full_now) begin
								err = 1'b1;
							end else begin
								count_n = count_q + 1'b1;
								ram_we  = 1'b1;
								if (is_empty_now) begin
									back_idx_n  = front_idx_q;
									ram_waddr   = front_idx_q;
									front_val_n = req_push_value;
									back_val_n  = req_push_value;
								end else if (req_op == OP_PUSH_FRONT) begin
									front_idx_n = front_dec;
									ram_waddr   = front_dec;
									front_val_n = req_push_value;
								end else begin
									back_idx_n = back_inc;
									ram_waddr  = back_inc;
									back_val_n = req_push_value;
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (is_empty_now) begin
								err = 1'b1;
							end else begin
								count_n     = count_q - 1'b1;
								pop_front_n = (req_op == OP_POP_FRONT);
								popped_n    = (req_op == OP_POP_FRONT) ? front_val_q : back_val_q;
								// fetch the new end value unless the queue drains
								if (count_q != CW'(1)) begin
									done    = 1'b0;
									state_n = ST_READ;
									ram_re  = 1'b1;
									if (req_op == OP_POP_FRONT) begin
										front_idx_n = front_inc;
										ram_raddr   = front_inc;
									end else begin
										back_idx_n = back_dec;
										ram_raddr  = back_dec;
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				done    = 1'b1;
				state_n = ST_IDLE;
				if (pop_front_q) begin
					front_val_n = ram_rdata;
				end else begin
					back_val_n = ram_rdata;
				end
			end
		endcase

		result.popped_value = popped_n;
		result.front_value  = (count_n != '0) ? front_val_n : '0;
		result.back_value   = (count_n != '0) ? back_val_n : '0;
		result.is_empty     = (count_n == '0);
		result.is_full      = (count_n == FULL_CNT);
		result.op_error     = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= '0;
			count_q     <= '0;
			pop_front_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			front_idx_q <= front_idx_n;
			back_idx_q  <= back_idx_n;
			count_q     <= count_n;
			pop_front_q <= pop_front_n;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		front_val_q <= front_val_n;
		back_val_q  <= back_val_n;
		popped_q    <= popped_n;
		if (done) begin
			out_data_q <= result;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_data_q;

endmodule

[rtl/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_checker import deq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic signed [DATA_W-1:0] rsp_front_value,
	input logic signed [DATA_W-1:0] rsp_back_value,
	input logic                     rsp_is_empty,
	input logic                     rsp_is_full
);

	// hold a stalled result word
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// take a new word only when the pending result leaves
	`ASSERT_IMPL(a_no_overrun, req_valid && req_ready && rsp_valid, rsp_ready)

	`ASSERT_IMPL(a_empty_full_excl, rsp_valid, !(rsp_is_empty && rsp_is_full))

	// an empty queue peeks as zero at both ends
	`ASSERT_IMPL(a_empty_peek_zero, rsp_valid && rsp_is_empty,
		rsp_front_value == '0 && rsp_back_value == '0)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_front_value (rsp.front_value),
	.rsp_back_value  (rsp.back_value),
	.rsp_is_empty    (rsp.is_empty),
	.rsp_is_full     (rsp.is_full)
);

[tb/tb_double_ended_queue.sv]
// Self-checking testbench for the bounded double-ended queue.
// Uses deq_pkg, deq_req_if and deq_rsp_if; predicts every result word in the testbench itself.
module tb_double_ended_queue import deq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh80000000;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		int                       reps;
		bit                       typed;
		deq_result_t              want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	deq_req_if req_if ();
	deq_rsp_if rsp_if ();

	double_ended_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the queue
	logic signed [DATA_W-1:0] slot_mem [DEQ_DEPTH];
	int front_ptr;
	int back_ptr;
	int elem_cnt;

	deq_result_t expected_q [$];
	stim_row_t   stim_rows [$];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          mismatch_cnt;
	int          stall_cycles;
	deq_result_t got_word;
	deq_result_t want_word;

	function automatic deq_result_t result_of(input logic signed [DATA_W-1:0] popped,
			input logic signed [DATA_W-1:0] front, input logic signed [DATA_W-1:0] back,
			input logic empty, input logic full, input logic err);
		deq_result_t r;
		r.popped_value = popped;
		r.front_value  = front;
		r.back_value   = back;
		r.is_empty     = empty;
		r.is_full      = full;
		r.op_error     = err;
		return r;
	endfunction

	// Apply one operation to the shadow queue and return the result word it yields.
	function automatic deq_result_t apply_op(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		deq_result_t r;
		r = '0;
		case (op)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (elem_cnt == DEQ_DEPTH) begin
				r.op_error = 1'b1;
			end else begin
				// first element lands on the front slot
				if (elem_cnt == 0) begin
					back_ptr = front_ptr;
				end else if (op == OP_PUSH_FRONT) begin
					front_ptr = (front_ptr == 0) ? DEQ_DEPTH - 1 : front_ptr - 1;
				end else begin
					back_ptr = (back_ptr == DEQ_DEPTH - 1) ? 0 : back_ptr + 1;
				end
				if (op == OP_PUSH_FRONT) slot_mem[front_ptr] = value;
				else slot_mem[back_ptr] = value;
				elem_cnt++;
			end
		end
		OP_POP_FRONT, OP_POP_BACK: begin
			if (elem_cnt == 0) begin
				r.op_error = 1'b1;
			end else if (op == OP_POP_FRONT) begin
				r.popped_value = slot_mem[front_ptr];
				elem_cnt--;
				if (elem_cnt != 0) front_ptr = (front_ptr == DEQ_DEPTH - 1) ? 0 : front_ptr + 1;
			end else begin
				r.popped_value = slot_mem[back_ptr];
				elem_cnt--;
				if (elem_cnt != 0) back_ptr = (back_ptr == 0) ? DEQ_DEPTH - 1 : back_ptr - 1;
			end
		end
		default: ;
		endcase
		r.front_value = (elem_cnt != 0) ? slot_mem[front_ptr] : '0;
		r.back_value  = (elem_cnt != 0) ? slot_mem[back_ptr] : '0;
		r.is_empty    = (elem_cnt == 0);
		r.is_full     = (elem_cnt == DEQ_DEPTH);
		return r;
	endfunction

	// Drive one word; the typed expectation replaces the predicted one when given.
	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
			input bit typed, input deq_result_t want);
		deq_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid      <= 1'b0;
			req_if.op         <= OP_W'($urandom);
			req_if.push_value <= $urandom;
			@(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.op         <= op;
		req_if.push_value <= value;
		do @(posedge clk); while (!req_if.ready);
		predicted = apply_op(op, value);
		expected_q.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Hold the sender off until every pending result has come back.
	task automatic drain_queue();
		req_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic run_directed();
		stim_rows = '{
			'{OP_POP_FRONT, 0, 1, 1'b1, result_of(0, 0, 0, 1'b1, 1'b0, 1'b1)},
			'{OP_POP_BACK, 0, 1, 1'b1, result_of(0, 0, 0, 1'b1, 1'b0, 1'b1)},
			'{OP_NOP, 32'sh1234, 1, 1'b1, result_of(0, 0, 0, 1'b1, 1'b0, 1'b0)},
			'{OP_RSVD7, -1, 1, 1'b1, result_of(0, 0, 0, 1'b1, 1'b0, 1'b0)},
			'{OP_PUSH_BACK, MAX_VAL, 1, 1'b1,
				result_of(0, MAX_VAL, MAX_VAL, 1'b0, 1'b0, 1'b0)},
			'{OP_PUSH_FRONT, MIN_VAL, 1, 1'b1,
				result_of(0, MIN_VAL, MAX_VAL, 1'b0, 1'b0, 1'b0)},
			'{OP_RSVD5, 0, 1, 1'b1, result_of(0, MIN_VAL, MAX_VAL, 1'b0, 1'b0, 1'b0)},
			'{OP_POP_BACK, 0, 1, 1'b1, result_of(MAX_VAL, MIN_VAL, MIN_VAL, 1'b0, 1'b0, 1'b0)},
			'{OP_POP_FRONT, 0, 1, 1'b1, result_of(MIN_VAL, 0, 0, 1'b1, 1'b0, 1'b0)},
			'{OP_PUSH_FRONT, -1, 1, 1'b1, result_of(0, -1, -1, 1'b0, 1'b0, 1'b0)},
			'{OP_RSVD6, MIN_VAL, 1, 1'b0, '0},
			'{OP_PUSH_BACK, 32'sh100, 8, 1'b0, '0},
			'{OP_PUSH_FRONT, 32'sh200, 7, 1'b0, '0},
			'{OP_PUSH_BACK, 32'sh55, 1, 1'b1,
				result_of(0, 32'sh206, 32'sh107, 1'b0, 1'b1, 1'b1)},
			'{OP_PUSH_FRONT, 32'sh66, 1, 1'b1,
				result_of(0, 32'sh206, 32'sh107, 1'b0, 1'b1, 1'b1)},
			'{OP_NOP, 0, 1, 1'b1, result_of(0, 32'sh206, 32'sh107, 1'b0, 1'b1, 1'b0)},
			'{OP_POP_BACK, 0, 9, 1'b0, '0},
			'{OP_POP_FRONT, 0, 7, 1'b0, '0},
			'{OP_POP_BACK, 0, 1, 1'b1, result_of(0, 0, 0, 1'b1, 1'b0, 1'b1)},
			'{OP_PUSH_BACK, 32'sh5A5A5A5A, 1, 1'b0, '0},
			'{OP_POP_FRONT, 0, 1, 1'b1, result_of(32'sh5A5A5A5A, 0, 0, 1'b1, 1'b0, 1'b0)}
		};
		foreach (stim_rows[i]) begin
			for (int k = 0; k < stim_rows[i].reps; k++) begin
				send_word(stim_rows[i].op, stim_rows[i].value + k, stim_rows[i].typed,
					stim_rows[i].want);
			end
		end
	endtask

	function automatic logic [OP_W-1:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < 3) return OP_NOP;
		if (r < 6) return OP_W'(OP_RSVD5 + $urandom_range(2));
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
		0: return MAX_VAL;
		1: return MIN_VAL;
		2: return '0;
		3: return -1;
		default: return $urandom;
		endcase
	endfunction

	// Run segments that lean toward filling, draining or neither, so both ends get hit often.
	task automatic run_random(input int n_words);
		int done;
		int seg_len;
		int push_pct;
		done = 0;
		while (done < n_words) begin
			seg_len = $urandom_range(10, 60);
			case ($urandom_range(2))
			0: push_pct = 80;
			1: push_pct = 20;
			default: push_pct = 50;
			endcase
			for (int k = 0; k < seg_len && done < n_words; k++) begin
				send_word(pick_op(push_pct), pick_value(), 1'b0, '0);
				done++;
			end
		end
	endtask

	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check result words and watch for a stalled channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (rsp_if.valid && rsp_if.ready) begin
				got_word = result_of(rsp_if.popped_value, rsp_if.front_value,
					rsp_if.back_value, rsp_if.is_empty, rsp_if.is_full, rsp_if.op_error);
				if (expected_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result word: popped %0d front %0d back %0d",
							got_word.popped_value, got_word.front_value, got_word.back_value);
				end else begin
					want_word = expected_q.pop_front();
					if (got_word.popped_value !== want_word.popped_value
							|| got_word.front_value !== want_word.front_value
							|| got_word.back_value !== want_word.back_value
							|| got_word.is_empty !== want_word.is_empty
							|| got_word.is_full !== want_word.is_full
							|| got_word.op_error !== want_word.op_error) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch (expected/actual): popped %0d/%0d front %0d/%0d",
								want_word.popped_value, got_word.popped_value,
								want_word.front_value, got_word.front_value);
							$display("  back %0d/%0d empty %b/%b full %b/%b error %b/%b",
								want_word.back_value, got_word.back_value,
								want_word.is_empty, got_word.is_empty,
								want_word.is_full, got_word.is_full,
								want_word.op_error, got_word.op_error);
						end
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		req_if.valid      = 1'b0;
		req_if.op         = OP_NOP;
		req_if.push_value = '0;
		rsp_if.ready      = 1'b0;
		send_idle_pct     = 13;
		recv_idle_pct     = 70;
		mismatch_cnt      = 0;
		stall_cycles      = 0;
		front_ptr         = 0;
		back_ptr          = 0;
		elem_cnt          = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 13;
				recv_idle_pct = 70;
				run_directed();
				run_random(600);
			end
			1: begin
				send_idle_pct = 70;
				recv_idle_pct = 13;
				run_random(600);
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				run_random(550);
			end
			endcase
			drain_queue();
		end
		// allow a stray late word to show up
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/deq_core.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/tb_double_ended_queue.sv
